// ===== hw/rtl/vn_pkg.sv =====
`default_nettype none
package vn_pkg;

    localparam int CompBits = 16;           // input component width
    localparam int SumBits  = 2 * CompBits; // x*x + y*y
    localparam int MagBits  = 24;           // root width
    localparam int RemBits  = MagBits + 2;  // partial remainder of the root
    localparam int QBits    = 15;           // quotient bits, unit <= 16384
    localparam int UnitBits = 16;
    localparam int PreShift = 7;            // 22 - QBits
    localparam logic [QBits-1:0] UnitOne = QBits'(16384);

    // one stage of the square root chain
    typedef struct packed {
        logic                valid;
        logic [SumBits-1:0]  rad;
        logic [RemBits-1:0]  rem;
        logic [MagBits-1:0]  root;
        logic [CompBits-1:0] ax;
        logic [CompBits-1:0] ay;
        logic                nx;
        logic                ny;
        logic                zero;
    } t_sq_stage;

    // one stage of the divider chain, both components side by side
    typedef struct packed {
        logic               valid;
        logic [MagBits-1:0] root;
        logic [MagBits-1:0] rx;
        logic [MagBits-1:0] ry;
        logic [QBits-1:0]   qx;
        logic [QBits-1:0]   qy;
        logic               nx;
        logic               ny;
        logic               zero;
    } t_div_stage;

endpackage
`default_nettype wire

// ===== hw/rtl/vn_in_if.sv =====
`default_nettype none
interface vn_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [vn_pkg::CompBits-1:0] vec_x;
    logic signed [vn_pkg::CompBits-1:0] vec_y;

    modport source (output valid, output vec_x, output vec_y, input ready);
    modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vn_out_if.sv =====
`default_nettype none
interface vn_out_if;
    logic                               valid;
    logic                               ready;
    logic [vn_pkg::MagBits-1:0]         magnitude;
    logic signed [vn_pkg::UnitBits-1:0] unit_x;
    logic signed [vn_pkg::UnitBits-1:0] unit_y;
    logic                               zero_vector;

    modport source (output valid, output magnitude, output unit_x, output unit_y,
                    output zero_vector, input ready);
    modport sink   (input valid, input magnitude, input unit_x, input unit_y,
                    input zero_vector, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vector2_normalize.sv =====
`default_nettype none
// Channel | Dir | Fields                                      | Handshake
// i_in    | in  | vec_x, vec_y (signed Q8.8)                  | valid/ready
// o_out   | out | magnitude, unit_x, unit_y, zero_vector      | valid/ready
//
// One transaction per cycle while o_out is not stalled; the chain is abs, square sum, 24 root
// cells, 15 divide cells, output register.
// The whole chain moves while the output register is empty or being taken;
// a stall on o_out freezes every stage, and i_in.ready follows the same enable.
// Synchronous active-low reset clears the valid bits only.
module vector2_normalize (
    input  wire      i_clk,
    input  wire      i_rst_n,
    vn_in_if.sink    i_in,
    vn_out_if.source o_out
);
    import vn_pkg::*;

    localparam int SqCells  = MagBits;
    localparam int DivCells = QBits;

    logic                w_en;
    // stage 0: magnitudes and signs
    logic                r_s0_valid;
    logic [CompBits-1:0] r_s0_ax;
    logic [CompBits-1:0] r_s0_ay;
    logic                r_s0_nx;
    logic                r_s0_ny;
    // stage 1: sum of squares
    logic                r_s1_valid;
    logic [SumBits-1:0]  r_s1_sum;
    logic [CompBits-1:0] r_s1_ax;
    logic [CompBits-1:0] r_s1_ay;
    logic                r_s1_nx;
    logic                r_s1_ny;
    logic [SumBits-1:0]  w_sqx;
    logic [SumBits-1:0]  w_sqy;

    t_sq_stage           w_sq  [0:SqCells];
    t_div_stage          w_div [0:DivCells];
    t_div_stage          w_last;
    logic [QBits-1:0]    w_qx;
    logic [QBits-1:0]    w_qy;

    logic                         r_out_valid;
    logic [MagBits-1:0]           r_mag;
    logic signed [UnitBits-1:0]   r_ux;
    logic signed [UnitBits-1:0]   r_uy;
    logic                         r_zero;

    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    // control valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid  <= i_in.valid;
            r_s1_valid  <= r_s0_valid;
            r_out_valid <= w_last.valid;
        end
    end

    // absolute values; the most negative code maps to 2^15 unsigned
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_nx <= i_in.vec_x[CompBits-1];
            r_s0_ny <= i_in.vec_y[CompBits-1];
            r_s0_ax <= i_in.vec_x[CompBits-1] ? CompBits'(-i_in.vec_x)
                                              : CompBits'(i_in.vec_x);
            r_s0_ay <= i_in.vec_y[CompBits-1] ? CompBits'(-i_in.vec_y)
                                              : CompBits'(i_in.vec_y);
        end
    end

    // square and sum
    assign w_sqx = r_s0_ax * r_s0_ax;
    assign w_sqy = r_s0_ay * r_s0_ay;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_sum <= w_sqx + w_sqy;
            r_s1_ax  <= r_s0_ax;
            r_s1_ay  <= r_s0_ay;
            r_s1_nx  <= r_s0_nx;
            r_s1_ny  <= r_s0_ny;
        end
    end

    // root chain head
    always_comb begin
        w_sq[0].valid = r_s1_valid;
        w_sq[0].rad   = r_s1_sum;
        w_sq[0].rem   = '0;
        w_sq[0].root  = '0;
        w_sq[0].ax    = r_s1_ax;
        w_sq[0].ay    = r_s1_ay;
        w_sq[0].nx    = r_s1_nx;
        w_sq[0].ny    = r_s1_ny;
        w_sq[0].zero  = (r_s1_sum == '0);
    end

    for (genvar g = 0; g < SqCells; g++) begin : g_sq
        vn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_prev  (w_sq[g]),
            .o_cur   (w_sq[g+1])
        );
    end

    // divider chain head: remainder starts at c * 2^7, which is below the root
    always_comb begin
        w_div[0].valid = w_sq[SqCells].valid;
        w_div[0].root  = w_sq[SqCells].root;
        w_div[0].rx    = MagBits'({w_sq[SqCells].ax, {PreShift{1'b0}}});
        w_div[0].ry    = MagBits'({w_sq[SqCells].ay, {PreShift{1'b0}}});
        w_div[0].qx    = '0;
        w_div[0].qy    = '0;
        w_div[0].nx    = w_sq[SqCells].nx;
        w_div[0].ny    = w_sq[SqCells].ny;
        w_div[0].zero  = w_sq[SqCells].zero;
    end

    for (genvar g = 0; g < DivCells; g++) begin : g_div
        vn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_prev  (w_div[g]),
            .o_cur   (w_div[g+1])
        );
    end

    assign w_last = w_div[DivCells];
    assign w_qx   = (w_last.qx > UnitOne) ? UnitOne : w_last.qx;
    assign w_qy   = (w_last.qy > UnitOne) ? UnitOne : w_last.qy;

    // output register: sign, saturation and the zero vector case
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero <= w_last.zero;
            r_mag  <= w_last.root;
            if (w_last.zero) begin
                r_ux <= '0;
                r_uy <= '0;
            end else begin
                r_ux <= w_last.nx ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
                r_uy <= w_last.ny ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.magnitude   = r_mag;
    assign o_out.unit_x      = r_ux;
    assign o_out.unit_y      = r_uy;
    assign o_out.zero_vector = r_zero;

`ifndef SYNTH
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_vector |->
            o_out.unit_x == 0 && o_out.unit_y == 0 && o_out.magnitude == 0)
        else $error("zero vector result not all zero");

    a_mag_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.zero_vector |-> o_out.magnitude >= MagBits'(256))
        else $error("nonzero vector with length below one LSB of input");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> r_ux <= 16384 && r_ux >= -16384
                     && r_uy <= 16384 && r_uy >= -16384)
        else $error("unit component out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_last.valid) && !i_in.ready == !w_en)
        else $error("chain moved during output stall");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/vn_sqrt_cell.sv =====
`default_nettype none
module vn_sqrt_cell (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  vn_pkg::t_sq_stage  i_prev,
    output vn_pkg::t_sq_stage  o_cur
);
    import vn_pkg::*;

    t_sq_stage          r_st;
    t_sq_stage          n_st;
    logic [RemBits+1:0] w_try;
    logic [RemBits+1:0] w_trial;

    // one root bit: bring down the next pair, compare with 4*root+1
    always_comb begin
        w_try   = {i_prev.rem, i_prev.rad[SumBits-1 -: 2]};
        w_trial = {2'b00, i_prev.root, 2'b01};
        n_st     = i_prev;
        n_st.rad = {i_prev.rad[SumBits-3:0], 2'b00};
        if (w_try >= w_trial) begin
            n_st.rem  = RemBits'(w_try - w_trial);
            n_st.root = {i_prev.root[MagBits-2:0], 1'b1};
        end else begin
            n_st.rem  = w_try[RemBits-1:0];
            n_st.root = {i_prev.root[MagBits-2:0], 1'b0};
        end
    end

    // stage register; reset clears the valid bit only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st.valid <= n_st.valid;
        end
        if (i_en) begin
            r_st.rad  <= n_st.rad;
            r_st.rem  <= n_st.rem;
            r_st.root <= n_st.root;
            r_st.ax   <= n_st.ax;
            r_st.ay   <= n_st.ay;
            r_st.nx   <= n_st.nx;
            r_st.ny   <= n_st.ny;
            r_st.zero <= n_st.zero;
        end
    end

    assign o_cur = r_st;
endmodule
`default_nettype wire

// ===== hw/rtl/vn_div_cell.sv =====
`default_nettype none
module vn_div_cell (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_en,
    input  vn_pkg::t_div_stage i_prev,
    output vn_pkg::t_div_stage o_cur
);
    import vn_pkg::*;

    t_div_stage       r_st;
    t_div_stage       n_st;
    logic [MagBits:0] w_tx;
    logic [MagBits:0] w_ty;
    logic [MagBits:0] w_d;

    // one quotient bit per lane, shared divisor
    always_comb begin
        w_tx = {i_prev.rx, 1'b0};
        w_ty = {i_prev.ry, 1'b0};
        w_d  = {1'b0, i_prev.root};
        n_st = i_prev;
        if (w_tx >= w_d) begin
            n_st.rx = MagBits'(w_tx - w_d);
            n_st.qx = {i_prev.qx[QBits-2:0], 1'b1};
        end else begin
            n_st.rx = w_tx[MagBits-1:0];
            n_st.qx = {i_prev.qx[QBits-2:0], 1'b0};
        end
        if (w_ty >= w_d) begin
            n_st.ry = MagBits'(w_ty - w_d);
            n_st.qy = {i_prev.qy[QBits-2:0], 1'b1};
        end else begin
            n_st.ry = w_ty[MagBits-1:0];
            n_st.qy = {i_prev.qy[QBits-2:0], 1'b0};
        end
    end

    // stage register; reset clears the valid bit only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else if (i_en) begin
            r_st.valid <= n_st.valid;
        end
        if (i_en) begin
            r_st.root <= n_st.root;
            r_st.rx   <= n_st.rx;
            r_st.ry   <= n_st.ry;
            r_st.qx   <= n_st.qx;
            r_st.qy   <= n_st.qy;
            r_st.nx   <= n_st.nx;
            r_st.ny   <= n_st.ny;
            r_st.zero <= n_st.zero;
        end
    end

    assign o_cur = r_st;
endmodule
`default_nettype wire
